>>> design/abb_pkg.sv
// Shared constants and the trig table generator for the arc bounding box unit.
package abb_pkg;

    localparam int unsigned COORD_BITS_DEF     = 16;
    localparam int unsigned TRIG_FRAC_BITS_DEF = 16;

    localparam int unsigned ANG_IN_BITS  = 14;
    localparam int unsigned ANG_RED_BITS = 13;
    localparam int unsigned ANG_QR_BITS  = 11;
    localparam int unsigned ROM_ADDR_BITS = 10;

    localparam int unsigned ANG_FULL = 5760;
    localparam int unsigned ANG_Q1   = 90 * 16;
    localparam int unsigned ANG_Q2   = 180 * 16;
    localparam int unsigned ANG_Q3   = 270 * 16;
    localparam int unsigned ANG_Q1W  = (90 + 360) * 16;
    localparam int unsigned ANG_Q2W  = (180 + 360) * 16;
    localparam int unsigned ANG_Q3W  = (270 + 360) * 16;
    localparam int unsigned ROM_LAST = ANG_Q1 / 2;

    localparam logic [127:0] PI4_Q32 = 128'd3373259426;
    localparam logic [63:0]  ONE_Q32 = 64'h0000_0001_0000_0000;

    localparam int unsigned SIN_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};
    localparam int unsigned COS_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

    // Taylor series in unsigned Q32.32, each term derived from the previous one.
    function automatic logic [63:0] series_q32(input logic [63:0] first,
                                               input logic [63:0] x2,
                                               input logic sin_sel);
        logic [127:0] term;
        logic [63:0]  sum;
        sum  = first;
        term = {64'd0, first};
        for (int k = 0; k < 8; k++) begin
            term = (term * {64'd0, x2}) >> 32;
            if (sin_sel) begin
                term = term / 128'(SIN_DIV[k]);
            end else begin
                term = term / 128'(COS_DIV[k]);
            end
            if (k[0]) begin
                sum = sum + term[63:0];
            end else begin
                sum = sum - term[63:0];
            end
        end
        return sum;
    endfunction

    // Sine or cosine of a/720 of an eighth turn, rounded to frac_bits fraction bits.
    function automatic logic [63:0] trig_entry(input int unsigned a,
                                               input logic sin_sel,
                                               input int unsigned frac_bits);
        logic [127:0] x;
        logic [127:0] x2;
        logic [63:0]  v;
        x  = (128'(a) * PI4_Q32 + 128'd360) / 128'd720;
        x2 = (x * x) >> 32;
        v  = series_q32(sin_sel ? x[63:0] : ONE_Q32, x2[63:0], sin_sel);
        return (v + (64'd1 << (31 - frac_bits))) >> (32 - frac_bits);
    endfunction

endpackage

>>> design/arc_bounding_box_unit.sv
// Pipelined bounding box of a circular arc given by center, radius and two angles.
//
//  Channel  | Handshake             | Signals
//  ---------+-----------------------+------------------------------------------------
//  command  | start, busy           | i_center_x, i_center_y, i_radius,
//           |                       | i_start_angle, i_stop_angle
//  result   | o_done (strobe)       | o_box_left, o_box_top, o_box_width, o_box_height
//
// One arc enters per cycle and busy is always low; each box leaves from the last stage.
// The eight register stages are: angle reduction, quadrant split, table address,
// table read, radius multiply, endpoint add, extent select and size subtract.
// Reset clears the valid bits of every stage; data registers are not reset.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module arc_bounding_box_unit #(
    parameter int unsigned COORD_BITS     = abb_pkg::COORD_BITS_DEF,
    parameter int unsigned TRIG_FRAC_BITS = abb_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [COORD_BITS-1:0]         i_center_x,
    input  logic signed [COORD_BITS-1:0]         i_center_y,
    input  logic        [COORD_BITS-2:0]         i_radius,
    input  logic        [abb_pkg::ANG_IN_BITS-1:0] i_start_angle,
    input  logic        [abb_pkg::ANG_IN_BITS-1:0] i_stop_angle,
    output logic                                 o_done,
    output logic signed [COORD_BITS:0]           o_box_left,
    output logic signed [COORD_BITS:0]           o_box_top,
    output logic        [COORD_BITS-1:0]         o_box_width,
    output logic        [COORD_BITS-1:0]         o_box_height
);

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned F  = TRIG_FRAC_BITS;
    localparam int unsigned TW = F + 1;
    localparam int unsigned RW = C - 1;
    localparam int unsigned PW = RW + TW;
    localparam int unsigned AB = abb_pkg::ANG_RED_BITS;
    localparam int unsigned QB = abb_pkg::ANG_QR_BITS;
    localparam int unsigned MB = abb_pkg::ROM_ADDR_BITS;

    typedef logic [2*TW-1:0] t_rom [0:abb_pkg::ROM_LAST];

    typedef struct packed {
        logic [1:0]    q;
        logic [QB-1:0] r;
    } t_quad;

    typedef struct packed {
        logic cos_use_sin;
        logic cos_neg;
        logic sin_neg;
    } t_sel;

    typedef struct packed {
        logic full;
        logic wrap;
        logic cross_q1;
        logic cross_q2;
        logic cross_q3;
    } t_flags;

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] s;
        logic [63:0] c;
        for (int a = 0; a <= int'(abb_pkg::ROM_LAST); a++) begin
            s = abb_pkg::trig_entry(a, 1'b1, F);
            c = abb_pkg::trig_entry(a, 1'b0, F);
            rom[a] = {s[TW-1:0], c[TW-1:0]};
        end
        return rom;
    endfunction

    localparam t_rom TRIG_ROM = build_rom();

    function automatic logic [AB-1:0] reduce_angle(input logic [abb_pkg::ANG_IN_BITS-1:0] a);
        logic [abb_pkg::ANG_IN_BITS-1:0] res;
        if (a >= 14'(2 * abb_pkg::ANG_FULL)) begin
            res = a - 14'(2 * abb_pkg::ANG_FULL);
        end else if (a >= 14'(abb_pkg::ANG_FULL)) begin
            res = a - 14'(abb_pkg::ANG_FULL);
        end else begin
            res = a;
        end
        return res[AB-1:0];
    endfunction

    function automatic t_quad split_quad(input logic [AB-1:0] a);
        t_quad         res;
        logic [AB-1:0] diff;
        if (a >= AB'(abb_pkg::ANG_Q3)) begin
            res.q = 2'd3;
            diff  = a - AB'(abb_pkg::ANG_Q3);
        end else if (a >= AB'(abb_pkg::ANG_Q2)) begin
            res.q = 2'd2;
            diff  = a - AB'(abb_pkg::ANG_Q2);
        end else if (a >= AB'(abb_pkg::ANG_Q1)) begin
            res.q = 2'd1;
            diff  = a - AB'(abb_pkg::ANG_Q1);
        end else begin
            res.q = 2'd0;
            diff  = a;
        end
        res.r = diff[QB-1:0];
        return res;
    endfunction

    function automatic logic [MB-1:0] rom_addr(input t_quad qd);
        logic [QB-1:0] a;
        if (qd.r > QB'(abb_pkg::ROM_LAST)) begin
            a = QB'(abb_pkg::ANG_Q1) - qd.r;
        end else begin
            a = qd.r;
        end
        return a[MB-1:0];
    endfunction

    function automatic t_sel quad_sel(input t_quad qd);
        t_sel s;
        s.cos_use_sin = qd.q[0] ^ (qd.r > QB'(abb_pkg::ROM_LAST));
        s.cos_neg     = (qd.q == 2'd1) || (qd.q == 2'd2);
        s.sin_neg     = qd.q[1];
        return s;
    endfunction

    function automatic logic crosses(input logic [AB:0] b, input logic [AB:0] ne,
                                     input logic [AB:0] n, input logic [AB:0] m);
        return ((b <= n) && (ne >= n)) || ((b <= m) && (ne >= m));
    endfunction

    function automatic logic signed [C:0] add_off(input logic signed [C-1:0] base,
                                                  input logic [RW-1:0] off,
                                                  input logic neg);
        logic signed [C:0] b_ext;
        logic signed [C:0] o_ext;
        b_ext = {base[C-1], base};
        o_ext = {2'b00, off};
        return neg ? (b_ext - o_ext) : (b_ext + o_ext);
    endfunction

    // Stage 1: angle reduction.
    logic                 r_v1;
    logic signed [C-1:0]  r_cx1, r_cy1;
    logic [RW-1:0]        r_rad1;
    logic [AB-1:0]        r_b1, r_e1;

    // Stage 2: quadrant split and crossing tests.
    logic                 r_v2;
    logic signed [C-1:0]  r_cx2, r_cy2;
    logic [RW-1:0]        r_rad2;
    t_quad                r_qb2, r_qe2;
    t_flags               r_fl2;
    t_flags               n_fl2;
    logic [AB:0]          n_ne2;

    // Stage 3: table address.
    logic                 r_v3;
    logic signed [C-1:0]  r_cx3, r_cy3;
    logic [RW-1:0]        r_rad3;
    logic [MB-1:0]        r_ab3, r_ae3;
    t_sel                 r_sb3, r_se3;
    t_flags               r_fl3;

    // Stage 4: table read.
    logic                 r_v4;
    logic signed [C-1:0]  r_cx4, r_cy4;
    logic [RW-1:0]        r_rad4;
    logic [2*TW-1:0]      r_rom_b4, r_rom_e4;
    t_sel                 r_sb4, r_se4;
    t_flags               r_fl4;

    // Stage 5: radius times trig magnitude.
    logic                 r_v5;
    logic signed [C-1:0]  r_cx5, r_cy5;
    logic [RW-1:0]        r_rad5;
    logic [PW-1:0]        r_pxb5, r_pyb5, r_pxe5, r_pye5;
    t_sel                 r_sb5, r_se5;
    t_flags               r_fl5;
    logic [TW-1:0]        n_cmb, n_smb, n_cme, n_sme;

    // Stage 6: endpoints and circle extremes.
    logic                 r_v6;
    logic signed [C:0]    r_xb6, r_yb6, r_xe6, r_ye6;
    logic signed [C:0]    r_cxm6, r_cxp6, r_cym6, r_cyp6;
    t_flags               r_fl6;

    // Stage 7: box edges.
    logic                 r_v7;
    logic signed [C:0]    r_l7, r_t7, r_r7, r_bt7;
    logic signed [C:0]    n_l7, n_t7, n_r7, n_bt7;

    // Stage 8: outputs.
    logic                 r_v8;
    logic signed [C:0]    r_left8, r_top8;
    logic [C-1:0]         r_width8, r_height8;
    logic signed [C:0]    n_width8, n_height8;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx1  <= i_center_x;
        r_cy1  <= i_center_y;
        r_rad1 <= i_radius;
        r_b1   <= reduce_angle(i_start_angle);
        r_e1   <= reduce_angle(i_stop_angle);
    end

    always_comb begin
        n_fl2.full = (r_b1 == r_e1);
        n_fl2.wrap = (r_b1 > r_e1);
        n_ne2      = n_fl2.wrap ? ({1'b0, r_e1} + (AB+1)'(abb_pkg::ANG_FULL)) : {1'b0, r_e1};
        n_fl2.cross_q1 = crosses({1'b0, r_b1}, n_ne2, (AB+1)'(abb_pkg::ANG_Q1),
                                 (AB+1)'(abb_pkg::ANG_Q1W));
        n_fl2.cross_q2 = crosses({1'b0, r_b1}, n_ne2, (AB+1)'(abb_pkg::ANG_Q2),
                                 (AB+1)'(abb_pkg::ANG_Q2W));
        n_fl2.cross_q3 = crosses({1'b0, r_b1}, n_ne2, (AB+1)'(abb_pkg::ANG_Q3),
                                 (AB+1)'(abb_pkg::ANG_Q3W));
    end

    always_ff @(posedge i_clk) begin
        r_cx2  <= r_cx1;
        r_cy2  <= r_cy1;
        r_rad2 <= r_rad1;
        r_qb2  <= split_quad(r_b1);
        r_qe2  <= split_quad(r_e1);
        r_fl2  <= n_fl2;
    end

    always_ff @(posedge i_clk) begin
        r_cx3  <= r_cx2;
        r_cy3  <= r_cy2;
        r_rad3 <= r_rad2;
        r_ab3  <= rom_addr(r_qb2);
        r_ae3  <= rom_addr(r_qe2);
        r_sb3  <= quad_sel(r_qb2);
        r_se3  <= quad_sel(r_qe2);
        r_fl3  <= r_fl2;
    end

    always_ff @(posedge i_clk) begin
        r_cx4    <= r_cx3;
        r_cy4    <= r_cy3;
        r_rad4   <= r_rad3;
        r_rom_b4 <= TRIG_ROM[r_ab3];
        r_rom_e4 <= TRIG_ROM[r_ae3];
        r_sb4    <= r_sb3;
        r_se4    <= r_se3;
        r_fl4    <= r_fl3;
    end

    // Table words hold sine in the upper half and cosine in the lower half.
    always_comb begin
        n_cmb = r_sb4.cos_use_sin ? r_rom_b4[2*TW-1:TW] : r_rom_b4[TW-1:0];
        n_smb = r_sb4.cos_use_sin ? r_rom_b4[TW-1:0]    : r_rom_b4[2*TW-1:TW];
        n_cme = r_se4.cos_use_sin ? r_rom_e4[2*TW-1:TW] : r_rom_e4[TW-1:0];
        n_sme = r_se4.cos_use_sin ? r_rom_e4[TW-1:0]    : r_rom_e4[2*TW-1:TW];
    end

    always_ff @(posedge i_clk) begin
        r_cx5  <= r_cx4;
        r_cy5  <= r_cy4;
        r_rad5 <= r_rad4;
        r_pxb5 <= PW'(r_rad4) * PW'(n_cmb);
        r_pyb5 <= PW'(r_rad4) * PW'(n_smb);
        r_pxe5 <= PW'(r_rad4) * PW'(n_cme);
        r_pye5 <= PW'(r_rad4) * PW'(n_sme);
        r_sb5  <= r_sb4;
        r_se5  <= r_se4;
        r_fl5  <= r_fl4;
    end

    always_ff @(posedge i_clk) begin
        r_xb6  <= add_off(r_cx5, r_pxb5[F +: RW], r_sb5.cos_neg);
        r_yb6  <= add_off(r_cy5, r_pyb5[F +: RW], !r_sb5.sin_neg);
        r_xe6  <= add_off(r_cx5, r_pxe5[F +: RW], r_se5.cos_neg);
        r_ye6  <= add_off(r_cy5, r_pye5[F +: RW], !r_se5.sin_neg);
        r_cxm6 <= add_off(r_cx5, r_rad5, 1'b1);
        r_cxp6 <= add_off(r_cx5, r_rad5, 1'b0);
        r_cym6 <= add_off(r_cy5, r_rad5, 1'b1);
        r_cyp6 <= add_off(r_cy5, r_rad5, 1'b0);
        r_fl6  <= r_fl5;
    end

    always_comb begin
        if (r_fl6.full) begin
            n_l7  = r_cxm6;
            n_t7  = r_cym6;
            n_r7  = r_cxp6;
            n_bt7 = r_cyp6;
        end else begin
            n_l7  = (r_xb6 < r_xe6) ? r_xb6 : r_xe6;
            n_r7  = (r_xb6 > r_xe6) ? r_xb6 : r_xe6;
            n_t7  = (r_yb6 < r_ye6) ? r_yb6 : r_ye6;
            n_bt7 = (r_yb6 > r_ye6) ? r_yb6 : r_ye6;
            if (r_fl6.wrap) begin
                n_r7 = r_cxp6;
            end
            if (r_fl6.cross_q1) begin
                n_t7 = r_cym6;
            end
            if (r_fl6.cross_q2) begin
                n_l7 = r_cxm6;
            end
            if (r_fl6.cross_q3) begin
                n_bt7 = r_cyp6;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_l7  <= n_l7;
        r_t7  <= n_t7;
        r_r7  <= n_r7;
        r_bt7 <= n_bt7;
    end

    assign n_width8  = r_r7 - r_l7;
    assign n_height8 = r_bt7 - r_t7;

    always_ff @(posedge i_clk) begin
        r_left8   <= r_l7;
        r_top8    <= r_t7;
        r_width8  <= n_width8[C-1:0];
        r_height8 <= n_height8[C-1:0];
    end

    assign o_done       = r_v8;
    assign o_box_left   = r_left8;
    assign o_box_top    = r_top8;
    assign o_box_width  = r_width8;
    assign o_box_height = r_height8;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the pipelined arc bounding box unit.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned CW = abb_pkg::COORD_BITS_DEF;
    localparam int unsigned FRAC = abb_pkg::TRIG_FRAC_BITS_DEF;
    localparam longint unsigned QUARTER_PI_Q32 = 64'd3373259426;
    localparam longint unsigned UNITY_Q32 = 64'h0000_0001_0000_0000;
    localparam int unsigned HALF_STEPS = abb_pkg::ROM_LAST;
    localparam int unsigned ANG_MAX = (1 << abb_pkg::ANG_IN_BITS) - 1;

    typedef struct {
        logic signed [CW-1:0]                 center_x;
        logic signed [CW-1:0]                 center_y;
        logic        [CW-2:0]                 radius;
        logic        [abb_pkg::ANG_IN_BITS-1:0] start_angle;
        logic        [abb_pkg::ANG_IN_BITS-1:0] stop_angle;
    } t_arc;

    typedef struct {
        logic signed [CW:0]   left;
        logic signed [CW:0]   top;
        logic        [CW-1:0] width;
        logic        [CW-1:0] height;
    } t_box;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic signed [CW-1:0]            i_center_x;
    logic signed [CW-1:0]            i_center_y;
    logic        [CW-2:0]            i_radius;
    logic [abb_pkg::ANG_IN_BITS-1:0] i_start_angle;
    logic [abb_pkg::ANG_IN_BITS-1:0] i_stop_angle;
    logic                            o_done;
    logic signed [CW:0]              o_box_left;
    logic signed [CW:0]              o_box_top;
    logic        [CW-1:0]            o_box_width;
    logic        [CW-1:0]            o_box_height;

    longint sine_rom   [0:HALF_STEPS];
    longint cosine_rom [0:HALF_STEPS];
    t_box   expected_boxes [$];
    int     error_count = 0;

    arc_bounding_box_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_start_angle (i_start_angle),
        .i_stop_angle  (i_stop_angle),
        .o_done        (o_done),
        .o_box_left    (o_box_left),
        .o_box_top     (o_box_top),
        .o_box_width   (o_box_width),
        .o_box_height  (o_box_height)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint taylor_q16(input longint unsigned first,
                                          input longint unsigned x2,
                                          input int unsigned n0);
        longint unsigned sum;
        longint unsigned term;
        int unsigned     n;
        sum  = first;
        term = first;
        n    = n0;
        for (int k = 0; k < 8; k++) begin
            term = (term * x2) >> 32;
            term = term / longint'((n + 1) * (n + 2));
            n    = n + 2;
            if (k % 2 == 1) begin
                sum = sum + term;
            end else begin
                sum = sum - term;
            end
        end
        return longint'((sum + (64'd1 << (31 - FRAC))) >> (32 - FRAC));
    endfunction

    function automatic void angle_trig(input int unsigned ang,
                                       output longint sin_v, output longint cos_v);
        int unsigned quad;
        int unsigned rem;
        int unsigned idx;
        longint      rs;
        longint      rc;
        quad = (ang / abb_pkg::ANG_Q1) % 4;
        rem  = ang % abb_pkg::ANG_Q1;
        idx  = (rem <= HALF_STEPS) ? rem : abb_pkg::ANG_Q1 - rem;
        rs   = (rem <= HALF_STEPS) ? sine_rom[idx] : cosine_rom[idx];
        rc   = (rem <= HALF_STEPS) ? cosine_rom[idx] : sine_rom[idx];
        case (quad)
            0: begin
                cos_v = rc;
                sin_v = rs;
            end
            1: begin
                cos_v = -rs;
                sin_v = rc;
            end
            2: begin
                cos_v = -rc;
                sin_v = -rs;
            end
            default: begin
                cos_v = rs;
                sin_v = -rc;
            end
        endcase
    endfunction

    function automatic longint radius_times(input longint rad, input longint trig_v);
        longint mag;
        longint prod;
        mag  = (trig_v < 0) ? -trig_v : trig_v;
        prod = (rad * mag) >> FRAC;
        return (trig_v < 0) ? -prod : prod;
    endfunction

    function automatic bit passes_through(input int unsigned b, input int unsigned e,
                                          input int unsigned n, input int unsigned m);
        return (b <= n && e >= n) || (b <= m && e >= m);
    endfunction

    function automatic t_box predict_box(input t_arc arc);
        longint      cx;
        longint      cy;
        longint      rad;
        longint      sb;
        longint      cb;
        longint      se;
        longint      ce;
        longint      xb;
        longint      yb;
        longint      xe;
        longint      ye;
        longint      lft;
        longint      tp;
        longint      rgt;
        longint      btm;
        int unsigned b;
        int unsigned e;
        int unsigned ne;
        t_box        box;
        cx  = longint'(arc.center_x);
        cy  = longint'(arc.center_y);
        rad = longint'(arc.radius);
        b   = int'(arc.start_angle) % abb_pkg::ANG_FULL;
        e   = int'(arc.stop_angle) % abb_pkg::ANG_FULL;
        if (b == e) begin
            lft = cx - rad;
            tp  = cy - rad;
            rgt = cx + rad;
            btm = cy + rad;
        end else begin
            angle_trig(b, sb, cb);
            angle_trig(e, se, ce);
            xb  = cx + radius_times(rad, cb);
            yb  = cy - radius_times(rad, sb);
            xe  = cx + radius_times(rad, ce);
            ye  = cy - radius_times(rad, se);
            lft = (xb < xe) ? xb : xe;
            rgt = (xb > xe) ? xb : xe;
            tp  = (yb < ye) ? yb : ye;
            btm = (yb > ye) ? yb : ye;
            if (b > e) begin
                rgt = cx + rad;
                ne  = e + abb_pkg::ANG_FULL;
            end else begin
                ne = e;
            end
            if (passes_through(b, ne, abb_pkg::ANG_Q1, abb_pkg::ANG_Q1W)) tp = cy - rad;
            if (passes_through(b, ne, abb_pkg::ANG_Q2, abb_pkg::ANG_Q2W)) lft = cx - rad;
            if (passes_through(b, ne, abb_pkg::ANG_Q3, abb_pkg::ANG_Q3W)) btm = cy + rad;
        end
        box.left   = lft[CW:0];
        box.top    = tp[CW:0];
        box.width  = CW'(rgt - lft);
        box.height = CW'(btm - tp);
        return box;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_box want;
        if (i_rst_n === 1'b1) begin
            if (o_done !== 1'b0 && o_done !== 1'b1) begin
                report_mismatch("o_done not driven", 0, 1);
            end else if (o_done) begin
                if (expected_boxes.size() == 0) begin
                    report_mismatch("unexpected result, left", o_box_left, 0);
                end else begin
                    want = expected_boxes.pop_front();
                    if (o_box_left !== want.left)
                        report_mismatch("box_left", o_box_left, want.left);
                    if (o_box_top !== want.top)
                        report_mismatch("box_top", o_box_top, want.top);
                    if (o_box_width !== want.width)
                        report_mismatch("box_width", o_box_width, want.width);
                    if (o_box_height !== want.height)
                        report_mismatch("box_height", o_box_height, want.height);
                end
            end
        end
    end

    // A transfer happens at the edge where start is high and busy is low.
    task automatic send_arc(input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy,
                            input logic [CW-2:0] rad, input int unsigned b,
                            input int unsigned e, input int idle_pct);
        t_arc arc;
        arc.center_x    = cx;
        arc.center_y    = cy;
        arc.radius      = rad;
        arc.start_angle = b[abb_pkg::ANG_IN_BITS-1:0];
        arc.stop_angle  = e[abb_pkg::ANG_IN_BITS-1:0];
        start         <= 1'b1;
        i_center_x    <= arc.center_x;
        i_center_y    <= arc.center_y;
        i_radius      <= arc.radius;
        i_start_angle <= arc.start_angle;
        i_stop_angle  <= arc.stop_angle;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_boxes.push_back(predict_box(arc));
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic test_full_circles();
        send_arc(0, 0, 0, 0, 0, 0);
        send_arc(32767, -32768, 32767, 0, abb_pkg::ANG_FULL, 0);
        send_arc(-32768, 32767, 32767, ANG_MAX, ANG_MAX % abb_pkg::ANG_FULL, 0);
        send_arc(100, -100, 1000, 2 * abb_pkg::ANG_FULL, 0, 0);
        send_arc(-32768, -32768, 32767, abb_pkg::ANG_Q1,
                 abb_pkg::ANG_Q1 + abb_pkg::ANG_FULL, 0);
        send_arc(5, 5, 0, 3, 3000, 0);
    endtask

    task automatic test_quadrant_arcs();
        send_arc(1000, 2000, 500, 0, abb_pkg::ANG_Q1, 0);
        send_arc(-1000, 2000, 500, abb_pkg::ANG_Q1, abb_pkg::ANG_Q2, 0);
        send_arc(1000, -2000, 500, abb_pkg::ANG_Q2, abb_pkg::ANG_Q3, 0);
        send_arc(0, 0, 32767, abb_pkg::ANG_Q3, abb_pkg::ANG_FULL, 0);
        send_arc(32767, 32767, 32767, 5000, 100, 0);
        send_arc(-32768, -32768, 32767, 100, 5000, 0);
        send_arc(0, 0, 12345, 1, abb_pkg::ANG_FULL - 1, 0);
        send_arc(0, 0, 12345, abb_pkg::ANG_FULL - 1, 1, 0);
        send_arc(300, -300, 20000, 720, 3600, 0);
        send_arc(-7, 9, 32767, abb_pkg::ANG_Q1 - 1, abb_pkg::ANG_Q1 + 1, 0);
        send_arc(7, -9, 32767, abb_pkg::ANG_Q2 - 1, abb_pkg::ANG_Q2 + 1, 0);
        send_arc(7, 9, 32767, abb_pkg::ANG_Q3 - 1, abb_pkg::ANG_Q3 + 1, 0);
        send_arc(32767, -32768, 32767, ANG_MAX, 2 * abb_pkg::ANG_FULL - 1, 0);
        send_arc(-1, 1, 32766, abb_pkg::ANG_Q1 + abb_pkg::ANG_FULL,
                 abb_pkg::ANG_Q3 + abb_pkg::ANG_FULL, 0);
        send_arc(0, 0, 1, abb_pkg::ANG_Q2, 0, 0);
    endtask

    function automatic int unsigned random_angle();
        case ($urandom_range(3))
            0: return $urandom_range(11) * abb_pkg::ANG_Q1;
            1: return ($urandom_range(11) * abb_pkg::ANG_Q1 + ANG_MAX) % (ANG_MAX + 1);
            2: return $urandom_range(11) * abb_pkg::ANG_Q1 + 1;
            default: return $urandom_range(ANG_MAX);
        endcase
    endfunction

    task automatic test_random_arcs(input int count, input int idle_pct);
        int unsigned   b;
        int unsigned   e;
        logic [CW-2:0] rad;
        for (int n = 0; n < count; n++) begin
            b = random_angle();
            case ($urandom_range(7))
                0: e = b;
                1: e = (b + abb_pkg::ANG_FULL <= ANG_MAX) ? b + abb_pkg::ANG_FULL
                                                          : b % abb_pkg::ANG_FULL;
                default: e = random_angle();
            endcase
            case ($urandom_range(15))
                0: rad = '0;
                1: rad = '1;
                default: rad = (CW-1)'($urandom);
            endcase
            send_arc(CW'($urandom), CW'($urandom), rad, b, e, idle_pct);
        end
    endtask

    initial begin
        longint unsigned x;
        longint unsigned x2;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_center_x    <= '0;
        i_center_y    <= '0;
        i_radius      <= '0;
        i_start_angle <= '0;
        i_stop_angle  <= '0;
        for (int a = 0; a <= HALF_STEPS; a++) begin
            x  = (longint'(a) * QUARTER_PI_Q32 + 360) / 720;
            x2 = (x * x) >> 32;
            sine_rom[a]   = taylor_q16(x, x2, 1);
            cosine_rom[a] = taylor_q16(UNITY_Q32, x2, 0);
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_circles();
        test_quadrant_arcs();
        test_random_arcs(250, 0);
        test_random_arcs(250, 72);
        test_random_arcs(250, 18);
        test_random_arcs(250, 0);
        start <= 1'b0;

        while (expected_boxes.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
